// ===== rtl/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package ptts_pkg;
  localparam int MaxTasks = 16;
  localparam int MaxJobs  = 32;
  localparam int TaskIdxW = $clog2(MaxTasks);
  localparam int JobIdxW  = $clog2(MaxJobs);
  localparam int TaskIdW  = 5;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTick = 1'b1;

  localparam logic [1:0] RegPolicy = 2'd0;
  localparam logic [1:0] RegKill   = 2'd1;
  localparam logic [1:0] RegStart  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [15:0] task_start;
    logic [15:0] task_period;
    logic [15:0] task_exec;
  } in_beat_t;

  typedef struct packed {
    logic        ran;
    logic [4:0]  run_task;
    logic [15:0] run_job;
    logic [15:0] run_slice;
    logic [5:0]  misses_now;
    logic [31:0] misses_total;
    logic [31:0] active_ticks;
    logic [31:0] tick_time;
    logic        overflow;
  } out_beat_t;

  // task entry: start, period, exec, job counter
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] period;
    logic [15:0] exec;
    logic [15:0] jcnt;
  } task_ent_t;

  // job entry
  typedef struct packed {
    logic [TaskIdW-1:0] tid;
    logic [15:0] num;
    logic [31:0] dl;
    logic [15:0] rmk;
    logic [15:0] done;
    logic [15:0] need;
  } job_ent_t;

  localparam int TaskEntW = $bits(task_ent_t);
  localparam int JobEntW  = $bits(job_ent_t);
endpackage
`default_nettype wire

// ===== rtl/ptts_ram.sv =====
// ----------------------------------------------------------------------------
// ptts_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ptts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/ptts_mod.sv =====
// ----------------------------------------------------------------------------
// ptts_mod
// Iterative remainder unit: checks whether period divides (t - start).
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ptts_mod
  import ptts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             busy_o,
  output logic             zero_o
);
  logic [31:0] n_q;
  logic [16:0] r_q;
  logic [15:0] d_q;
  logic [5:0]  cnt_q;
  logic [16:0] sh;
  always_comb sh = {r_q[15:0], n_q[31]};
  assign busy_o = cnt_q != 6'd0;
  assign zero_o = r_q == 17'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      r_q   <= '0;
    end else if (start_i) begin
      cnt_q <= 6'd32;
      r_q   <= '0;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 6'd1;
      r_q   <= (sh >= {1'b0, d_q}) ? sh - {1'b0, d_q} : sh;
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
    end else if (busy_o) begin
      n_q <= {n_q[30:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/periodic_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Tick-driven periodic scheduler, rate monotonic or earliest deadline first.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one beat is either a task load (func 0) or a tick (func 1).
//   out channel: exactly one result beat per input beat, in order.
//   APB port: policy_edf at 0x0, kill_late at 0x4, clock start value at 0x8;
//   writing the start value also reloads the clock. Write only while idle.
// Sequence (one item at a time):
//   load: result registered at the accepting edge.
//   tick: a pass over the job RAM to retire and count misses, then per
//   loaded task a task RAM read and release test, waiting on the remainder
//   unit when the release test needs it, then a select pass over the job
//   RAM, then S_OUT builds the result. The winner is written back in S_WB,
//   after the result goes valid.
// Reset: job valid bits, task count, counters cleared; clock = start register.
// The task and job RAMs are not cleared; only loaded/valid entries are used.
// Stall: the result sits in an output register; in_ready_o stays low until
//   it is taken, then the next beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_task_tick_scheduler
  import ptts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_TRD, S_TWAIT, S_MOD, S_REL, S_SEL, S_SELW, S_WB, S_OUT
  } state_e;

  state_e state_q;
  logic policy_q, kill_q;
  logic [15:0] start_q;
  logic [31:0] clock_q, misst_q, act_q;
  logic [TaskIdxW:0] tcnt_q;
  logic [MaxJobs-1:0] valid_q;
  logic [JobIdxW:0] jidx_q;
  logic [TaskIdxW:0] tidx_q;
  logic [5:0] miss_q;
  logic ovf_q;
  logic best_ok_q;
  logic [JobIdxW-1:0] best_q;
  job_ent_t best_e_q;
  task_ent_t tent_q;
  out_beat_t out_q;
  logic out_v_q;

  // APB
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegPolicy: prdata = {31'd0, policy_q};
      RegKill:   prdata = {31'd0, kill_q};
      RegStart:  prdata = {16'd0, start_q};
      default:   prdata = '0;
    endcase
  end

  // task RAM
  logic t_we;
  logic [TaskIdxW-1:0] t_wa, t_ra;
  task_ent_t t_wd, t_rd;
  ptts_ram #(.Width(TaskEntW), .Depth(MaxTasks)) u_tram (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd),
    .raddr_i(t_ra), .rdata_o(t_rd)
  );

  // job RAM
  logic j_we;
  logic [JobIdxW-1:0] j_wa, j_ra;
  job_ent_t j_wd, j_rd;
  ptts_ram #(.Width(JobEntW), .Depth(MaxJobs)) u_jram (
    .clk_i, .we_i(j_we), .waddr_i(j_wa), .wdata_i(j_wd),
    .raddr_i(j_ra), .rdata_o(j_rd)
  );

  // remainder unit
  logic m_start, m_busy, m_zero;
  ptts_mod u_mod (
    .clk_i, .rst_ni, .start_i(m_start), .num_i(clock_q - {16'd0, tent_q.start}),
    .den_i(tent_q.period), .busy_o(m_busy), .zero_o(m_zero)
  );

  // task may release this tick if period nonzero and clock at or past its start
  logic rel_ok;
  assign rel_ok = tent_q.period != 16'd0 && clock_q >= {16'd0, tent_q.start};

  // first free slot
  logic free_ok;
  logic [JobIdxW-1:0] free_idx;
  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int k = MaxJobs - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_ok = 1'b1;
        free_idx = JobIdxW'(k);
      end
    end
  end

  // ordering of the job just read against the current best
  logic [JobIdxW-1:0] prev_j;
  logic [31:0] ka, kb;
  logic ahead;
  assign prev_j = jidx_q[JobIdxW-1:0] - JobIdxW'(1);
  always_comb begin
    ka = policy_q ? j_rd.dl : {16'd0, j_rd.rmk};
    kb = policy_q ? best_e_q.dl : {16'd0, best_e_q.rmk};
    if (ka != kb) ahead = ka < kb;
    else if (j_rd.num != best_e_q.num) ahead = j_rd.num < best_e_q.num;
    else ahead = j_rd.tid < best_e_q.tid;
  end

  // saturating totals for the result
  logic [32:0] miss_sum;
  logic [31:0] misst_d, act_d;
  assign miss_sum = {1'b0, misst_q} + {27'd0, miss_q};
  assign misst_d = miss_sum[32] ? '1 : miss_sum[31:0];
  assign act_d = (best_ok_q && act_q != '1) ? act_q + 32'd1 : act_q;

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE) && !out_v_q;
  assign in_acc = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  always_comb begin
    t_we = 1'b0;
    t_wa = tcnt_q[TaskIdxW-1:0];
    t_wd = '{start: in_data_i.task_start, period: in_data_i.task_period,
             exec: in_data_i.task_exec, jcnt: 16'd0};
    t_ra = tidx_q[TaskIdxW-1:0];
    j_we = 1'b0;
    j_wa = free_idx;
    j_wd = '{tid: TaskIdW'(tidx_q) + TaskIdW'(1), num: tent_q.jcnt,
             dl: clock_q + {16'd0, tent_q.period}, rmk: tent_q.period,
             done: 16'd0, need: tent_q.exec};
    j_ra = jidx_q[JobIdxW-1:0];
    m_start = 1'b0;
    if (in_acc && in_data_i.func == FuncLoad && tcnt_q < (TaskIdxW+1)'(MaxTasks))
      t_we = 1'b1;
    unique case (state_q)
      // tent_q holds the entry just read
      S_MOD: m_start = rel_ok;
      S_REL: begin
        if (!m_busy && rel_ok && m_zero && free_ok) begin
          j_we = 1'b1;
          t_we = 1'b1;
          t_wa = tidx_q[TaskIdxW-1:0];
          t_wd = tent_q;
          t_wd.jcnt = tent_q.jcnt + 16'd1;
        end
      end
      S_WB: begin
        j_we = 1'b1;
        j_wa = best_q;
        j_wd = best_e_q;
        if (best_e_q.done != 16'hFFFF) j_wd.done = best_e_q.done + 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      policy_q <= 1'b0; kill_q <= 1'b0; start_q <= '0;
      clock_q <= '0; misst_q <= '0; act_q <= '0;
      tcnt_q <= '0; valid_q <= '0; jidx_q <= '0; tidx_q <= '0;
      miss_q <= '0; ovf_q <= 1'b0; best_ok_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (wr) begin
        unique case (paddr[3:2])
          RegPolicy: policy_q <= pwdata[0];
          RegKill:   kill_q <= pwdata[0];
          RegStart: begin
            start_q <= pwdata[15:0];
            clock_q <= {16'd0, pwdata[15:0]};
          end
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          miss_q <= '0; ovf_q <= 1'b0; tidx_q <= '0;
          best_ok_q <= 1'b0;
          if (in_data_i.func == FuncLoad) begin
            jidx_q <= '0;
            if (tcnt_q < (TaskIdxW+1)'(MaxTasks)) tcnt_q <= tcnt_q + 1'b1;
            out_q <= '{ran: 1'b0, run_task: '0, run_job: '0, run_slice: '0,
                       misses_now: '0, misses_total: misst_q, active_ticks: act_q,
                       tick_time: clock_q,
                       overflow: !(tcnt_q < (TaskIdxW+1)'(MaxTasks))};
            out_v_q <= 1'b1;
          end else begin
            jidx_q <= (JobIdxW+1)'(1);
            state_q <= S_SCAN;
          end
        end
        // entry prev_j is on the read port
        S_SCAN: begin
          if (valid_q[prev_j]) begin
            if (j_rd.done >= j_rd.need) valid_q[prev_j] <= 1'b0;
            else if (j_rd.dl == clock_q) begin
              if (miss_q != 6'd63) miss_q <= miss_q + 6'd1;
              if (kill_q) valid_q[prev_j] <= 1'b0;
            end
          end
          if (jidx_q == (JobIdxW+1)'(MaxJobs)) begin
            jidx_q <= '0;
            state_q <= (tcnt_q == '0) ? S_SEL : S_TRD;
          end else jidx_q <= jidx_q + 1'b1;
        end
        S_TRD: state_q <= S_TWAIT;
        S_TWAIT: begin
          tent_q <= t_rd;
          state_q <= S_MOD;
        end
        S_MOD: state_q <= S_REL;
        S_REL: if (!m_busy) begin
          if (rel_ok && m_zero) begin
            if (free_ok) valid_q[free_idx] <= 1'b1;
            else ovf_q <= 1'b1;
          end
          if (tidx_q + 1'b1 == tcnt_q) begin
            jidx_q <= '0;
            state_q <= S_SEL;
          end else begin
            tidx_q <= tidx_q + 1'b1;
            state_q <= S_TRD;
          end
        end
        S_SEL: begin
          jidx_q <= (JobIdxW+1)'(1);
          state_q <= S_SELW;
        end
        S_SELW: begin
          if (valid_q[prev_j] && (!best_ok_q || ahead)) begin
            best_ok_q <= 1'b1;
            best_q <= prev_j;
            best_e_q <= j_rd;
          end
          if (jidx_q == (JobIdxW+1)'(MaxJobs)) state_q <= S_OUT;
          else jidx_q <= jidx_q + 1'b1;
        end
        S_OUT: begin
          out_q <= '{ran: best_ok_q,
                     run_task: best_ok_q ? best_e_q.tid : '0,
                     run_job: best_ok_q ? best_e_q.num : '0,
                     run_slice: best_ok_q ? best_e_q.done + 16'd1 : '0,
                     misses_now: miss_q, misses_total: misst_d,
                     active_ticks: act_d, tick_time: clock_q, overflow: ovf_q};
          misst_q <= misst_d;
          act_q <= act_d;
          clock_q <= clock_q + 32'd1;
          out_v_q <= 1'b1;
          state_q <= best_ok_q ? S_WB : S_IDLE;
        end
        S_WB: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_v_q) else $error("input taken while result pending");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcnt_q <= (TaskIdxW+1)'(MaxTasks)) else $error("task count overrun");
  a_wb_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WB |-> best_ok_q) else $error("write-back without winner");
endmodule
`default_nettype wire
